### design/cycle_count_timer_run_controller_unit_defines.svh
// Assertion macros shared by the run controller modules.
// Each expects a clock named clock and an active-high reset named reset.
`ifndef CYCLE_COUNT_TIMER_RUN_CONTROLLER_UNIT_DEFINES_SVH
`define CYCLE_COUNT_TIMER_RUN_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CCR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ccr_pkg.sv
// Types and constants for the run controller.
// Used by the channel interfaces, the percent divider and the top level.
package ccr_pkg;

   localparam int CYCLE_TARGET_W = 30;
   localparam int TIME_TARGET_W  = 17;
   localparam int SPEED_W        = 7;
   localparam int STEPS_W        = 16;
   localparam int CSR_DATA_W     = 30;
   localparam int CSR_INDEX_W    = 2;
   localparam int PCT_W          = 7;
   localparam int DUTY_W         = 8;
   localparam int OUT_COUNT_W    = 32;
   localparam int CMD_W          = 3;
   localparam int MODE_W         = 3;
   localparam int DIV_NUM_W      = 37;
   localparam int DIV_STEPS      = 7;
   localparam int DIV_COUNT_W    = 3;
   localparam int DUTY_SHIFT     = 22;
   localparam int DUTY_RECIP_W   = 24;
   localparam int DUTY_PROD_W    = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_TARGET    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_TARGET     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_PERCENT   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_CYCLE = 2'd3;

   localparam logic [SPEED_W-1:0]      SPEED_MIN   = 7'd30;
   localparam logic [SPEED_W-1:0]      SPEED_MAX   = 7'd100;
   localparam logic [SPEED_W-1:0]      SPEED_RESET = 7'd100;
   localparam logic [STEPS_W-1:0]      STEPS_RESET = 16'd187;
   localparam logic [STEPS_W-1:0]      STEPS_MAX   = 16'hFFFF;
   localparam logic [PCT_W-1:0]        PCT_FULL    = 7'd100;
   localparam logic [DUTY_RECIP_W-1:0] DUTY_RECIP  = 24'd10695720;

   typedef enum logic [CMD_W-1:0] {
      CMD_STEP         = 3'd0,
      CMD_TICK         = 3'd1,
      CMD_SET_REQUEST  = 3'd2,
      CMD_RESET_TOTALS = 3'd3,
      CMD_POLL         = 3'd4
   } command_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE    = 3'd0,
      MODE_RUN     = 3'd1,
      MODE_COUNTER = 3'd2,
      MODE_TIMER   = 3'd3,
      MODE_BOTH    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EVENT,
      SEQ_CYC,
      SEQ_CYC_WAIT,
      SEQ_TIME,
      SEQ_TIME_WAIT,
      SEQ_FINISH
   } seq_type;

   typedef struct packed {
      logic                      start;
      logic [CYCLE_TARGET_W-1:0] dividend;
      logic [CYCLE_TARGET_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [PCT_W-1:0] quotient;
   } div_rsp_type;

endpackage

### design/ccr_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on ccr_pkg for field widths.
interface ccr_req_if;
   logic                      valid;
   logic                      ready;
   logic [ccr_pkg::CMD_W-1:0] command;
   logic                      request_value;

   modport source(output valid, command, request_value, input ready);
   modport sink(input valid, command, request_value, output ready);
endinterface

interface ccr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ccr_pkg::MODE_W-1:0]      run_state;
   logic                            motor_enable;
   logic [ccr_pkg::DUTY_W-1:0]      pwm_duty;
   logic [ccr_pkg::PCT_W-1:0]       progress_percent;
   logic [ccr_pkg::OUT_COUNT_W-1:0] cycles_completed;
   logic [ccr_pkg::OUT_COUNT_W-1:0] elapsed_seconds;
   logic                            request_active;

   modport source(output valid, run_state, motor_enable, pwm_duty, progress_percent,
                  cycles_completed, elapsed_seconds, request_active, input ready);
   modport sink(input valid, run_state, motor_enable, pwm_duty, progress_percent,
                cycles_completed, elapsed_seconds, request_active, output ready);
endinterface

### design/ccr_div.sv
// Restoring divider for percent: quotient of dividend*100 by divisor, one bit a cycle.
// Depends on ccr_pkg and the assertion macro header.
`include "cycle_count_timer_run_controller_unit_defines.svh"

module ccr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ccr_pkg::div_req_type div_req,
   output ccr_pkg::div_rsp_type div_rsp
);

   logic [ccr_pkg::DIV_NUM_W-1:0]   rem_ff, rem_in;
   logic [ccr_pkg::DIV_NUM_W-1:0]   dsh_ff, dsh_in;
   logic [ccr_pkg::DIV_COUNT_W-1:0] count_ff, count_in;
   logic [ccr_pkg::PCT_W-1:0]       q_ff, q_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic                            fits;

   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      count_in = count_ff;
      q_in     = q_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = ccr_pkg::DIV_NUM_W'(div_req.dividend) * ccr_pkg::DIV_NUM_W'(100);
         dsh_in   = ccr_pkg::DIV_NUM_W'(div_req.divisor) << (ccr_pkg::DIV_STEPS - 1);
         count_in = ccr_pkg::DIV_COUNT_W'(ccr_pkg::DIV_STEPS - 1);
         q_in     = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[ccr_pkg::PCT_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      count_ff <= count_in;
      q_ff     <= q_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

   `CCR_ASSERT_IMPL(a_start_when_free, div_req.start, !busy_ff, "divider started while busy")
   `CCR_ASSERT_IMPL(a_done_not_busy, done_ff, !busy_ff, "divider done while still busy")
   `CCR_ASSERT_NEXT(a_done_single, done_ff, !done_ff, "divider done held for two cycles")

endmodule

### design/cycle_count_timer_run_controller_unit.sv
// Run controller: an item passes the event, cycle, time and finish steps from acceptance
// to a registered result, and uses the shared percent divider at most once in counter or
// timer state and at most twice in the both state. One item is in work at a time, so no
// new item is accepted until the last one has finished. A result waiting on the output
// does not block acceptance, but holds the next item at its final step until it leaves.
// Synchronous active-high reset clears the run state, totals and configuration registers
// to their documented values; no clearing pass is needed.
`include "cycle_count_timer_run_controller_unit_defines.svh"

module cycle_count_timer_run_controller_unit #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   ccr_req_if.sink                            req_chan,
   ccr_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [ccr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccr_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   ccr_pkg::seq_type  seq_ff, seq_in;
   ccr_pkg::mode_type mode_ff, mode_in;

   logic [ccr_pkg::CMD_W-1:0]          cmd_ff;
   logic                               rv_ff;
   logic                               req_flag_ff, req_flag_in;
   logic [ccr_pkg::STEPS_W-1:0]        step_acc_ff, step_acc_in;
   logic [COUNT_WIDTH-1:0]             cycle_total_ff, cycle_total_in;
   logic [COUNT_WIDTH-1:0]             second_total_ff, second_total_in;
   logic [ccr_pkg::PCT_W-1:0]          progress_ff, progress_in;
   logic [ccr_pkg::PCT_W-1:0]          pc_ff, pc_in;
   logic [ccr_pkg::PCT_W-1:0]          pt_ff, pt_in;

   logic [ccr_pkg::CYCLE_TARGET_W-1:0] cycle_target_ff;
   logic [ccr_pkg::TIME_TARGET_W-1:0]  time_target_ff;
   logic [ccr_pkg::SPEED_W-1:0]        speed_ff;
   logic [ccr_pkg::STEPS_W-1:0]        steps_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ccr_pkg::MODE_W-1:0]         rsp_state_ff, rsp_state_in;
   logic                               rsp_enable_ff, rsp_enable_in;
   logic [ccr_pkg::DUTY_W-1:0]         rsp_duty_ff, rsp_duty_in;
   logic [ccr_pkg::PCT_W-1:0]          rsp_progress_ff, rsp_progress_in;
   logic [ccr_pkg::OUT_COUNT_W-1:0]    rsp_cycles_ff, rsp_cycles_in;
   logic [ccr_pkg::OUT_COUNT_W-1:0]    rsp_seconds_ff, rsp_seconds_in;
   logic                               rsp_request_ff, rsp_request_in;

   ccr_pkg::div_req_type               div_req;
   ccr_pkg::div_rsp_type               div_rsp;

   logic [63:0]                        cyc64, sec64;
   logic [63:0]                        ctgt64, ttgt64;
   logic                               cyc_full, time_full;
   logic [ccr_pkg::STEPS_W-1:0]        acc_inc;
   logic [ccr_pkg::SPEED_W-1:0]        speed_cl;
   logic [ccr_pkg::DUTY_PROD_W-1:0]    duty_prod;
   logic [ccr_pkg::DUTY_W-1:0]         duty;
   logic [ccr_pkg::PCT_W-1:0]          pct_max;
   logic                               finish_go;
   logic                               enable;
   logic                               req_ok;

   ccr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign cyc64     = 64'(cycle_total_ff);
   assign sec64     = 64'(second_total_ff);
   assign ctgt64    = 64'(cycle_target_ff);
   assign ttgt64    = 64'(time_target_ff);
   assign cyc_full  = (cycle_target_ff == '0) || (cyc64 >= ctgt64);
   assign time_full = (time_target_ff == '0) || (sec64 >= ttgt64);
   assign acc_inc   = (step_acc_ff != ccr_pkg::STEPS_MAX) ? step_acc_ff + 1'b1 : step_acc_ff;
   assign pct_max   = (pc_ff > pt_ff) ? pc_ff : pt_ff;
   assign finish_go = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      if (speed_ff < ccr_pkg::SPEED_MIN) begin
         speed_cl = ccr_pkg::SPEED_MIN;
      end else if (speed_ff > ccr_pkg::SPEED_MAX) begin
         speed_cl = ccr_pkg::SPEED_MAX;
      end else begin
         speed_cl = speed_ff;
      end
   end

   assign duty_prod = ccr_pkg::DUTY_PROD_W'(speed_cl) * ccr_pkg::DUTY_PROD_W'(ccr_pkg::DUTY_RECIP);
   assign duty      = duty_prod[ccr_pkg::DUTY_SHIFT +: ccr_pkg::DUTY_W];

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = cyc64[ccr_pkg::CYCLE_TARGET_W-1:0];
      div_req.divisor  = cycle_target_ff;
      if (seq_ff == ccr_pkg::SEQ_TIME) begin
         div_req.dividend = sec64[ccr_pkg::CYCLE_TARGET_W-1:0];
         div_req.divisor  = ccr_pkg::CYCLE_TARGET_W'(time_target_ff);
      end
      if (seq_ff == ccr_pkg::SEQ_CYC) begin
         div_req.start = (mode_ff == ccr_pkg::MODE_COUNTER || mode_ff == ccr_pkg::MODE_BOTH)
                         && !cyc_full;
      end
      if (seq_ff == ccr_pkg::SEQ_TIME) begin
         div_req.start = (mode_ff == ccr_pkg::MODE_TIMER || mode_ff == ccr_pkg::MODE_BOTH)
                         && !time_full;
      end
   end

   always_comb begin
      seq_in          = seq_ff;
      mode_in         = mode_ff;
      req_flag_in     = req_flag_ff;
      step_acc_in     = step_acc_ff;
      cycle_total_in  = cycle_total_ff;
      second_total_in = second_total_ff;
      progress_in     = progress_ff;
      pc_in           = pc_ff;
      pt_in           = pt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_state_in    = rsp_state_ff;
      rsp_enable_in   = rsp_enable_ff;
      rsp_duty_in     = rsp_duty_ff;
      rsp_progress_in = rsp_progress_ff;
      rsp_cycles_in   = rsp_cycles_ff;
      rsp_seconds_in  = rsp_seconds_ff;
      rsp_request_in  = rsp_request_ff;
      enable          = 1'b0;
      req_ok          = 1'b0;
      unique case (seq_ff)
         ccr_pkg::SEQ_IDLE: begin
            if (req_chan.valid) begin
               seq_in = ccr_pkg::SEQ_EVENT;
            end
         end
         ccr_pkg::SEQ_EVENT: begin
            case (cmd_ff)
               ccr_pkg::CMD_STEP: begin
                  if (acc_inc >= steps_ff) begin
                     step_acc_in    = '0;
                     cycle_total_in = (cycle_total_ff == COUNT_MAX) ? cycle_total_ff
                                      : cycle_total_ff + 1'b1;
                  end else begin
                     step_acc_in = acc_inc;
                  end
               end
               ccr_pkg::CMD_TICK: begin
                  second_total_in = (second_total_ff == COUNT_MAX) ? second_total_ff
                                    : second_total_ff + 1'b1;
               end
               ccr_pkg::CMD_SET_REQUEST: begin
                  req_flag_in = rv_ff;
               end
               ccr_pkg::CMD_RESET_TOTALS: begin
                  mode_in         = ccr_pkg::MODE_IDLE;
                  req_flag_in     = 1'b0;
                  cycle_total_in  = '0;
                  second_total_in = '0;
               end
               default: begin
               end
            endcase
            seq_in = ccr_pkg::SEQ_CYC;
         end
         ccr_pkg::SEQ_CYC: begin
            pc_in  = ccr_pkg::PCT_FULL;
            seq_in = div_req.start ? ccr_pkg::SEQ_CYC_WAIT : ccr_pkg::SEQ_TIME;
         end
         ccr_pkg::SEQ_CYC_WAIT: begin
            if (div_rsp.done) begin
               pc_in  = div_rsp.quotient;
               seq_in = ccr_pkg::SEQ_TIME;
            end
         end
         ccr_pkg::SEQ_TIME: begin
            pt_in  = ccr_pkg::PCT_FULL;
            seq_in = div_req.start ? ccr_pkg::SEQ_TIME_WAIT : ccr_pkg::SEQ_FINISH;
         end
         ccr_pkg::SEQ_TIME_WAIT: begin
            if (div_rsp.done) begin
               pt_in  = div_rsp.quotient;
               seq_in = ccr_pkg::SEQ_FINISH;
            end
         end
         ccr_pkg::SEQ_FINISH: begin
            if (finish_go) begin
               enable = 1'b1;
               unique case (mode_ff)
                  ccr_pkg::MODE_RUN: begin
                     if (cycle_target_ff != '0) begin
                        mode_in = ccr_pkg::MODE_COUNTER;
                     end else if (time_target_ff != '0) begin
                        mode_in = ccr_pkg::MODE_TIMER;
                     end
                     if (!req_flag_ff) begin
                        mode_in = ccr_pkg::MODE_IDLE;
                     end
                  end
                  ccr_pkg::MODE_COUNTER: begin
                     progress_in = pc_ff;
                     if (!req_flag_ff || cyc64 >= ctgt64) begin
                        mode_in     = ccr_pkg::MODE_IDLE;
                        req_flag_in = 1'b0;
                     end else if (time_target_ff != '0) begin
                        mode_in = ccr_pkg::MODE_BOTH;
                     end
                  end
                  ccr_pkg::MODE_TIMER: begin
                     progress_in = pt_ff;
                     if (!req_flag_ff || sec64 >= ttgt64) begin
                        mode_in     = ccr_pkg::MODE_IDLE;
                        req_flag_in = 1'b0;
                     end else if (cycle_target_ff != '0) begin
                        mode_in = ccr_pkg::MODE_BOTH;
                     end
                  end
                  ccr_pkg::MODE_BOTH: begin
                     progress_in = pct_max;
                     if (!req_flag_ff || pct_max >= ccr_pkg::PCT_FULL) begin
                        mode_in     = ccr_pkg::MODE_IDLE;
                        req_flag_in = 1'b0;
                     end
                     if (time_target_ff == '0) begin
                        mode_in = ccr_pkg::MODE_COUNTER;
                     end
                     if (cycle_target_ff == '0) begin
                        mode_in = ccr_pkg::MODE_TIMER;
                     end
                  end
                  default: begin
                     enable = 1'b0;
                     if (req_flag_ff) begin
                        mode_in = ccr_pkg::MODE_RUN;
                     end
                  end
               endcase
               req_ok          = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_state_in    = mode_in;
               rsp_enable_in   = enable;
               rsp_duty_in     = enable ? duty : '0;
               rsp_progress_in = progress_in;
               rsp_cycles_in   = cyc64[ccr_pkg::OUT_COUNT_W-1:0];
               rsp_seconds_in  = sec64[ccr_pkg::OUT_COUNT_W-1:0];
               rsp_request_in  = req_flag_in;
               seq_in          = ccr_pkg::SEQ_IDLE;
            end
         end
         default: begin
            seq_in = ccr_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff          <= ccr_pkg::SEQ_IDLE;
         mode_ff         <= ccr_pkg::MODE_IDLE;
         req_flag_ff     <= 1'b0;
         step_acc_ff     <= '0;
         cycle_total_ff  <= '0;
         second_total_ff <= '0;
         progress_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         cycle_target_ff <= '0;
         time_target_ff  <= '0;
         speed_ff        <= ccr_pkg::SPEED_RESET;
         steps_ff        <= ccr_pkg::STEPS_RESET;
      end else begin
         seq_ff          <= seq_in;
         mode_ff         <= mode_in;
         req_flag_ff     <= req_flag_in;
         step_acc_ff     <= step_acc_in;
         cycle_total_ff  <= cycle_total_in;
         second_total_ff <= second_total_in;
         progress_ff     <= progress_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               ccr_pkg::CSR_CYCLE_TARGET: begin
                  cycle_target_ff <= csr_write_data;
               end
               ccr_pkg::CSR_TIME_TARGET: begin
                  time_target_ff <= csr_write_data[ccr_pkg::TIME_TARGET_W-1:0];
               end
               ccr_pkg::CSR_SPEED_PERCENT: begin
                  speed_ff <= csr_write_data[ccr_pkg::SPEED_W-1:0];
               end
               ccr_pkg::CSR_STEPS_PER_CYCLE: begin
                  steps_ff <= csr_write_data[ccr_pkg::STEPS_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      if (seq_ff == ccr_pkg::SEQ_IDLE && req_chan.valid) begin
         cmd_ff <= req_chan.command;
         rv_ff  <= req_chan.request_value;
      end
      pc_ff           <= pc_in;
      pt_ff           <= pt_in;
      rsp_state_ff    <= rsp_state_in;
      rsp_enable_ff   <= rsp_enable_in;
      rsp_duty_ff     <= rsp_duty_in;
      rsp_progress_ff <= rsp_progress_in;
      rsp_cycles_ff   <= rsp_cycles_in;
      rsp_seconds_ff  <= rsp_seconds_in;
      rsp_request_ff  <= rsp_request_in;
   end

   assign req_chan.ready            = (seq_ff == ccr_pkg::SEQ_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.run_state        = rsp_state_ff;
   assign rsp_chan.motor_enable     = rsp_enable_ff;
   assign rsp_chan.pwm_duty         = rsp_duty_ff;
   assign rsp_chan.progress_percent = rsp_progress_ff;
   assign rsp_chan.cycles_completed = rsp_cycles_ff;
   assign rsp_chan.elapsed_seconds  = rsp_seconds_ff;
   assign rsp_chan.request_active   = rsp_request_ff;

   `CCR_ASSERT_IMPL(a_progress_range, 1'b1, progress_ff <= ccr_pkg::PCT_FULL, "progress above full")
   `CCR_ASSERT_IMPL(a_duty_gated, rsp_valid_ff && !rsp_enable_ff, rsp_duty_ff == '0, "duty without enable")
   `CCR_ASSERT_NEXT(a_finish_issues, req_ok, rsp_valid_ff && seq_ff == ccr_pkg::SEQ_IDLE, "finish lost item")

endmodule

### tb/cycle_count_timer_run_controller_unit_tb.sv
// Self-checking testbench for the motor fixture run controller.
// Needs ccr_pkg, the ccr_req_if and ccr_rsp_if interfaces and the controller top level.
// Each result is compared against a cycle-free model of the event and run-machine pass.
`timescale 1ns / 1ps

module cycle_count_timer_run_controller_unit_tb;

   localparam logic [ccr_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [ccr_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [ccr_pkg::CMD_W-1:0] CMD_SPARE_C = 3'd7;
   localparam int DUTY_FULL    = 255;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 30;

   typedef struct {
      ccr_pkg::mode_type                run_state;
      logic                             motor_enable;
      logic [ccr_pkg::DUTY_W-1:0]       pwm_duty;
      logic [ccr_pkg::PCT_W-1:0]        progress_percent;
      logic [ccr_pkg::OUT_COUNT_W-1:0]  cycles_completed;
      logic [ccr_pkg::OUT_COUNT_W-1:0]  elapsed_seconds;
      logic                             request_active;
   } run_status_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write_enable;
   logic [ccr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ccr_pkg::CSR_DATA_W-1:0]  csr_write_data;

   ccr_req_if req_bus();
   ccr_rsp_if rsp_bus();

   cycle_count_timer_run_controller_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Model state and configuration copy.
   ccr_pkg::mode_type                  mdl_mode;
   logic                               mdl_request;
   logic [ccr_pkg::STEPS_W-1:0]        mdl_step_acc;
   logic [ccr_pkg::OUT_COUNT_W-1:0]    mdl_cycles;
   logic [ccr_pkg::OUT_COUNT_W-1:0]    mdl_seconds;
   logic [ccr_pkg::PCT_W-1:0]          mdl_progress;
   logic [ccr_pkg::CYCLE_TARGET_W-1:0] cfg_cycle_target;
   logic [ccr_pkg::TIME_TARGET_W-1:0]  cfg_time_target;
   logic [ccr_pkg::SPEED_W-1:0]        cfg_speed;
   logic [ccr_pkg::STEPS_W-1:0]        cfg_steps;

   run_status_type pending_status[$];
   int unsigned mismatch_count  = 0;
   int unsigned results_checked = 0;
   int unsigned items_sent      = 0;
   int unsigned phases_run      = 0;
   int unsigned burst_left      = 0;
   bit          gaps_on         = 1'b1;
   bit          hold_go         = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [ccr_pkg::OUT_COUNT_W-1:0] bump_saturating(
      logic [ccr_pkg::OUT_COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [ccr_pkg::PCT_W-1:0] percent_toward(
      logic [ccr_pkg::OUT_COUNT_W-1:0] done, logic [ccr_pkg::OUT_COUNT_W-1:0] target);
      logic [63:0] scaled;
      if (target == '0 || done >= target) return ccr_pkg::PCT_FULL;
      scaled = ({32'd0, done} * 64'd100) / {32'd0, target};
      return scaled[ccr_pkg::PCT_W-1:0];
   endfunction

   function automatic run_status_type advance_run_pass(logic [ccr_pkg::CMD_W-1:0] cmd,
                                                       logic rv);
      run_status_type            s;
      logic                      enable;
      logic [ccr_pkg::PCT_W-1:0] pc, pt;
      int                        speed;
      enable = 1'b0;
      case (cmd)
         ccr_pkg::CMD_STEP: begin
            if (mdl_step_acc != ccr_pkg::STEPS_MAX) mdl_step_acc = mdl_step_acc + 1'b1;
            if (mdl_step_acc >= cfg_steps) begin
               mdl_cycles   = bump_saturating(mdl_cycles);
               mdl_step_acc = '0;
            end
         end
         ccr_pkg::CMD_TICK: mdl_seconds = bump_saturating(mdl_seconds);
         ccr_pkg::CMD_SET_REQUEST: mdl_request = rv;
         ccr_pkg::CMD_RESET_TOTALS: begin
            mdl_mode    = ccr_pkg::MODE_IDLE;
            mdl_request = 1'b0;
            mdl_cycles  = '0;
            mdl_seconds = '0;
         end
         default: ;
      endcase
      case (mdl_mode)
         ccr_pkg::MODE_RUN: begin
            if (cfg_cycle_target != '0) mdl_mode = ccr_pkg::MODE_COUNTER;
            else if (cfg_time_target != '0) mdl_mode = ccr_pkg::MODE_TIMER;
            if (!mdl_request) mdl_mode = ccr_pkg::MODE_IDLE;
            enable = 1'b1;
         end
         ccr_pkg::MODE_COUNTER: begin
            mdl_progress = percent_toward(mdl_cycles, cfg_cycle_target);
            if (!mdl_request || mdl_cycles >= cfg_cycle_target) begin
               mdl_mode    = ccr_pkg::MODE_IDLE;
               mdl_request = 1'b0;
            end else if (cfg_time_target != '0) begin
               mdl_mode = ccr_pkg::MODE_BOTH;
            end
            enable = 1'b1;
         end
         ccr_pkg::MODE_TIMER: begin
            mdl_progress = percent_toward(mdl_seconds, cfg_time_target);
            if (!mdl_request || mdl_seconds >= cfg_time_target) begin
               mdl_mode    = ccr_pkg::MODE_IDLE;
               mdl_request = 1'b0;
            end else if (cfg_cycle_target != '0) begin
               mdl_mode = ccr_pkg::MODE_BOTH;
            end
            enable = 1'b1;
         end
         ccr_pkg::MODE_BOTH: begin
            pc = percent_toward(mdl_cycles, cfg_cycle_target);
            pt = percent_toward(mdl_seconds, cfg_time_target);
            mdl_progress = (pc > pt) ? pc : pt;
            if (!mdl_request || mdl_progress >= ccr_pkg::PCT_FULL) begin
               mdl_mode    = ccr_pkg::MODE_IDLE;
               mdl_request = 1'b0;
            end
            if (cfg_time_target == '0) mdl_mode = ccr_pkg::MODE_COUNTER;
            if (cfg_cycle_target == '0) mdl_mode = ccr_pkg::MODE_TIMER;
            enable = 1'b1;
         end
         default: begin
            if (mdl_request) mdl_mode = ccr_pkg::MODE_RUN;
            enable = 1'b0;
         end
      endcase
      speed = cfg_speed;
      if (speed < ccr_pkg::SPEED_MIN) speed = ccr_pkg::SPEED_MIN;
      else if (speed > ccr_pkg::SPEED_MAX) speed = ccr_pkg::SPEED_MAX;
      s.run_state        = mdl_mode;
      s.motor_enable     = enable;
      s.pwm_duty         = enable ? ccr_pkg::DUTY_W'((speed * DUTY_FULL) / 100) : '0;
      s.progress_percent = mdl_progress;
      s.cycles_completed = mdl_cycles;
      s.elapsed_seconds  = mdl_seconds;
      s.request_active   = mdl_request;
      return s;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      run_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_status.size() == 0) begin
            $error("result item arrived with no expected item pending");
            mismatch_count++;
         end else begin
            want = pending_status.pop_front();
            check_field("run_state", want.run_state, rsp_bus.run_state);
            check_field("motor_enable", want.motor_enable, rsp_bus.motor_enable);
            check_field("pwm_duty", want.pwm_duty, rsp_bus.pwm_duty);
            check_field("progress_percent", want.progress_percent, rsp_bus.progress_percent);
            check_field("cycles_completed", want.cycles_completed, rsp_bus.cycles_completed);
            check_field("elapsed_seconds", want.elapsed_seconds, rsp_bus.elapsed_seconds);
            check_field("request_active", want.request_active, rsp_bus.request_active);
            results_checked++;
         end
      end
   end

   // The receiver changes its stall pattern every so often and honors a long hold-off.
   initial begin
      int unsigned pattern_mode;
      int unsigned pattern_left;
      int unsigned tick_count;
      rsp_bus.ready = 1'b0;
      pattern_mode  = 0;
      pattern_left  = 0;
      tick_count    = 0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clock);
         end
         if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 200);
         end
         pattern_left--;
         tick_count++;
         case (pattern_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= (tick_count % 3 == 0);
         endcase
      end
   end

   task automatic send_item(logic [ccr_pkg::CMD_W-1:0] cmd, logic rv);
      int unsigned gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.command       <= cmd;
      req_bus.request_value <= rv;
      do @(posedge clock); while (!req_bus.ready);
      pending_status.push_back(advance_run_pass(cmd, rv));
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(logic [ccr_pkg::CYCLE_TARGET_W-1:0] cycles,
                             logic [ccr_pkg::TIME_TARGET_W-1:0] secs,
                             logic [ccr_pkg::SPEED_W-1:0] speed,
                             logic [ccr_pkg::STEPS_W-1:0] steps);
      drain_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= ccr_pkg::CSR_CYCLE_TARGET;
      csr_write_data   <= ccr_pkg::CSR_DATA_W'(cycles);
      @(negedge clock);
      csr_index        <= ccr_pkg::CSR_TIME_TARGET;
      csr_write_data   <= ccr_pkg::CSR_DATA_W'(secs);
      @(negedge clock);
      csr_index        <= ccr_pkg::CSR_SPEED_PERCENT;
      csr_write_data   <= ccr_pkg::CSR_DATA_W'(speed);
      @(negedge clock);
      csr_index        <= ccr_pkg::CSR_STEPS_PER_CYCLE;
      csr_write_data   <= ccr_pkg::CSR_DATA_W'(steps);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_cycle_target = cycles;
      cfg_time_target  = secs;
      cfg_speed        = speed;
      cfg_steps        = steps;
      phases_run++;
   endtask

   task automatic test_command_codes();
      send_item(ccr_pkg::CMD_POLL, 1'b0);
      send_item(CMD_SPARE_A, 1'b1);
      send_item(CMD_SPARE_B, 1'b0);
      send_item(CMD_SPARE_C, 1'b1);
      send_item(ccr_pkg::CMD_STEP, 1'b1);
      send_item(ccr_pkg::CMD_TICK, 1'b0);
      send_item(ccr_pkg::CMD_RESET_TOTALS, 1'b1);
      send_item(ccr_pkg::CMD_SET_REQUEST, 1'b0);
   endtask

   task automatic test_request_start_stop();
      send_item(ccr_pkg::CMD_SET_REQUEST, 1'b1);
      send_item(ccr_pkg::CMD_POLL, 1'b0);
      send_item(ccr_pkg::CMD_STEP, 1'b0);
      send_item(ccr_pkg::CMD_TICK, 1'b0);
      send_item(ccr_pkg::CMD_SET_REQUEST, 1'b0);
      send_item(ccr_pkg::CMD_SET_REQUEST, 1'b1);
      send_item(ccr_pkg::CMD_POLL, 1'b0);
      send_item(ccr_pkg::CMD_RESET_TOTALS, 1'b0);
   endtask

   task automatic test_cycle_and_timer_stops();
      set_config(30'd1, 17'd0, 7'd0, 16'd1);
      send_item(ccr_pkg::CMD_SET_REQUEST, 1'b1);
      send_item(ccr_pkg::CMD_POLL, 1'b0);
      send_item(ccr_pkg::CMD_STEP, 1'b0);
      set_config(30'd0, 17'd2, 7'd127, 16'd65535);
      send_item(ccr_pkg::CMD_SET_REQUEST, 1'b1);
      send_item(ccr_pkg::CMD_POLL, 1'b0);
      send_item(ccr_pkg::CMD_TICK, 1'b0);
      send_item(ccr_pkg::CMD_TICK, 1'b0);
      set_config(30'd3, 17'd5, 7'd31, 16'd0);
      send_item(ccr_pkg::CMD_RESET_TOTALS, 1'b0);
      send_item(ccr_pkg::CMD_SET_REQUEST, 1'b1);
      send_item(ccr_pkg::CMD_POLL, 1'b0);
      send_item(ccr_pkg::CMD_STEP, 1'b0);
      send_item(ccr_pkg::CMD_STEP, 1'b0);
      send_item(ccr_pkg::CMD_STEP, 1'b0);
   endtask

   task automatic test_output_backpressure();
      set_config(30'd0, 17'd0, 7'd29, 16'd2);
      gaps_on = 1'b0;
      hold_go = 1'b1;
      send_item(ccr_pkg::CMD_SET_REQUEST, 1'b1);
      for (int i = 0; i < 40; i++)
         send_item(($urandom_range(0, 1) == 0) ? ccr_pkg::CMD_STEP : ccr_pkg::CMD_TICK, 1'b0);
      gaps_on = 1'b1;
   endtask

   task automatic run_random_phase(int unsigned count, bit well_formed);
      logic [ccr_pkg::CYCLE_TARGET_W-1:0] cycles;
      logic [ccr_pkg::TIME_TARGET_W-1:0]  secs;
      logic [ccr_pkg::SPEED_W-1:0]        speed;
      logic [ccr_pkg::STEPS_W-1:0]        steps;
      int unsigned                        r;
      case ($urandom_range(0, 9))
         0, 1: cycles = '0;
         8: cycles = ccr_pkg::CYCLE_TARGET_W'($urandom_range(0, 30'h3FFFFFFF));
         9: cycles = $urandom_range(0, 1) ? 30'd1000000000 : 30'h3FFFFFFF;
         default: cycles = ccr_pkg::CYCLE_TARGET_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
         0, 1: secs = '0;
         8: secs = ccr_pkg::TIME_TARGET_W'($urandom_range(0, 17'h1FFFF));
         9: secs = $urandom_range(0, 1) ? 17'd86340 : 17'h1FFFF;
         default: secs = ccr_pkg::TIME_TARGET_W'($urandom_range(1, 10));
      endcase
      case ($urandom_range(0, 3))
         0: speed = $urandom_range(0, 1) ? 7'd0 : 7'd127;
         1: speed = ccr_pkg::SPEED_W'($urandom_range(28, 32));
         2: speed = ccr_pkg::SPEED_W'($urandom_range(98, 102));
         default: speed = ccr_pkg::SPEED_W'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 9))
         0, 1: steps = ccr_pkg::STEPS_W'($urandom_range(0, 1));
         8: steps = ccr_pkg::STEPS_W'($urandom_range(0, 65535));
         9: steps = 16'hFFFF;
         default: steps = ccr_pkg::STEPS_W'($urandom_range(2, 6));
      endcase
      set_config(cycles, secs, speed, steps);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (!well_formed) begin
            send_item(ccr_pkg::CMD_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         end else if (!mdl_request && mdl_mode == ccr_pkg::MODE_IDLE && r < 70) begin
            send_item(ccr_pkg::CMD_SET_REQUEST, 1'b1);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45) send_item(ccr_pkg::CMD_STEP, 1'($urandom_range(0, 1)));
            else if (r < 65) send_item(ccr_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
            else if (r < 77) send_item(ccr_pkg::CMD_POLL, 1'($urandom_range(0, 1)));
            else if (r < 85) send_item(ccr_pkg::CMD_SET_REQUEST, $urandom_range(0, 3) != 0);
            else if (r < 89) send_item(ccr_pkg::CMD_RESET_TOTALS, 1'($urandom_range(0, 1)));
            else send_item(ccr_pkg::CMD_W'(CMD_SPARE_A + $urandom_range(0, 2)),
                           1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 16; p++) run_random_phase(115, p % 8 != 7);
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.command       = ccr_pkg::CMD_POLL;
      req_bus.request_value = 1'b0;
      csr_write_enable      = 1'b0;
      csr_index             = ccr_pkg::CSR_CYCLE_TARGET;
      csr_write_data        = '0;
      mdl_mode         = ccr_pkg::MODE_IDLE;
      mdl_request      = 1'b0;
      mdl_step_acc     = '0;
      mdl_cycles       = '0;
      mdl_seconds      = '0;
      mdl_progress     = '0;
      cfg_cycle_target = '0;
      cfg_time_target  = '0;
      cfg_speed        = ccr_pkg::SPEED_RESET;
      cfg_steps        = ccr_pkg::STEPS_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_command_codes();
      test_request_start_stop();
      test_cycle_and_timer_stops();
      test_output_backpressure();
      test_random_phases();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items and checked %0d results across %0d register settings,",
               items_sent, results_checked, phases_run);
      $display("including a %0d-cycle output hold-off and every command code.", HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d results still expected.", pending_status.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/ccr_pkg.sv
design/ccr_if.sv
design/ccr_div.sv
design/cycle_count_timer_run_controller_unit.sv
tb/cycle_count_timer_run_controller_unit_tb.sv
